/* sv/eds_pkg.sv */
// Package for the equal digit sum counter.
// Holds the field widths, sequencer state codes and table-read select codes.
// No dependencies.
`default_nettype none

package eds_pkg;

    localparam int LEN_W   = 5;
    localparam int RAD_W   = 5;
    localparam int COUNT_W = 64;
    localparam int MUL_W   = 32;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [3:0]         state_t;
    typedef logic [1:0]         sel_t;

    // sequencer states
    localparam state_t ST_IDLE     = 4'd0;
    localparam state_t ST_START    = 4'd1;
    localparam state_t ST_CONV     = 4'd2;
    localparam state_t ST_CONV_END = 4'd3;
    localparam state_t ST_SQ_RD    = 4'd4;
    localparam state_t ST_SQ_M1    = 4'd5;
    localparam state_t ST_SQ_M2    = 4'd6;
    localparam state_t ST_SQ_ACC   = 4'd7;
    localparam state_t ST_ODD_M1   = 4'd8;
    localparam state_t ST_ODD_M2   = 4'd9;
    localparam state_t ST_ODD_ACC  = 4'd10;
    localparam state_t ST_DONE     = 4'd11;

    // what a table read returns
    localparam sel_t SEL_ZERO = 2'd0;
    localparam sel_t SEL_ONE  = 2'd1;
    localparam sel_t SEL_MEM  = 2'd2;

endpackage

`default_nettype wire

/* sv/equal_digit_sum_count.sv */
// Work: one convolution sweep per pass over the half length, then a square step and, when
//   the length is odd, a scale by the radix, both through the one 32x32 multiplier.
// Throughput: one item at a time; the next one is taken once the result is in the
//   output register. Invalid lengths, radices or spans go straight to done with zero.
// Reset: rst_n async, active low, clears sequencer and output valid; depends on eds_pkg.
`default_nettype none

module equal_digit_sum_count
    import eds_pkg::*;
#(
    parameter int MAX_HALF    = 8,
    parameter int MAX_BASE    = 16,
    parameter int TABLE_DEPTH = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [4:0] digit_count, [9:5] radix, [15:10] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [63:0] count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int DW = ((AW > RAD_W) ? AW : RAD_W) + 1;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [RAD_W-1:0]   rad_reg, rad_next;
    logic [AW-1:0]      top_reg, top_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [LEN_W-2:0]   pass_reg, pass_next;
    logic               init_reg, init_next;
    logic               bank_reg, bank_next;
    count_t             acc_reg, acc_next;
    logic               wr_valid_reg, wr_valid_next;
    logic [AW-1:0]      wr_idx_reg, wr_idx_next;
    sel_t               sel_a_reg, sel_a_next;
    sel_t               sel_b_reg, sel_b_next;
    count_t             x_reg, x_next;
    count_t             prod_lo_reg, prod_lo_next;
    logic [MUL_W-1:0]   prod_hi_reg, prod_hi_next;
    logic               m_tvalid_reg, m_tvalid_next;
    count_t             m_tdata_reg, m_tdata_next;

    count_t             hist_mem [2**(AW+1)];
    count_t             rd_a_reg, rd_b_reg;

    logic [LEN_W-2:0]   half;
    logic [RAD_W-1:0]   spread;
    logic [8:0]         span;
    logic               bad;
    logic [AW:0]        last_sum;
    logic [AW-1:0]      last;
    logic [DW-1:0]      diff;
    logic [AW-1:0]      idx_b;
    count_t             val_a, val_b, wsum;
    logic [MUL_W-1:0]   mul_a, mul_b;
    count_t             mul_p;
    logic [LEN_W-2:0]   pass_inc;

    assign half     = len_reg[LEN_W-1:1];
    assign spread   = (rad_reg == '0) ? '0 : rad_reg - RAD_W'(1);
    assign span     = 9'(half) * 9'(spread);
    assign bad      = (32'(len_reg) > 32'(2 * MAX_HALF + 1)) ||
                      (32'(rad_reg) > 32'(MAX_BASE)) ||
                      (32'(span) >= 32'(TABLE_DEPTH));
    assign last_sum = (AW+1)'(top_reg) + (AW+1)'(spread);
    assign last     = last_sum[AW-1:0];
    assign diff     = DW'(idx_reg) - DW'(rad_reg);
    assign idx_b    = diff[AW-1:0];
    assign pass_inc = pass_reg + (LEN_W-1)'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // table reads: the first pass sees a virtual table holding one at sum zero
    always_comb
    begin
        if (init_reg)
            sel_a_next = (idx_reg == '0) ? SEL_ONE : SEL_ZERO;
        else
            sel_a_next = (idx_reg <= top_reg) ? SEL_MEM : SEL_ZERO;

        if (diff[DW-1])
            sel_b_next = SEL_ZERO;
        else if (init_reg)
            sel_b_next = (idx_b == '0) ? SEL_ONE : SEL_ZERO;
        else
            sel_b_next = SEL_MEM;
    end

    always_comb
    begin
        case (sel_a_reg)
            SEL_MEM: val_a = rd_a_reg;
            SEL_ONE: val_a = count_t'(1);
            default: val_a = '0;
        endcase
        case (sel_b_reg)
            SEL_MEM: val_b = rd_b_reg;
            SEL_ONE: val_b = count_t'(1);
            default: val_b = '0;
        endcase
    end

    // sliding window over the prior table: add the entering term, drop the leaving one
    assign wsum = acc_reg + val_a - val_b;

    // shared 32x32 multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_SQ_M1:
            begin
                mul_a = val_a[MUL_W-1:0];
                mul_b = val_a[MUL_W-1:0];
            end
            ST_SQ_M2:
            begin
                mul_a = x_reg[MUL_W-1:0];
                mul_b = x_reg[COUNT_W-1:MUL_W];
            end
            ST_ODD_M1:
            begin
                mul_a = acc_reg[MUL_W-1:0];
                mul_b = MUL_W'(rad_reg);
            end
            ST_ODD_M2:
            begin
                mul_a = acc_reg[COUNT_W-1:MUL_W];
                mul_b = MUL_W'(rad_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = count_t'(mul_a) * count_t'(mul_b);

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        rad_next      = rad_reg;
        top_next      = top_reg;
        idx_next      = idx_reg;
        pass_next     = pass_reg;
        init_next     = init_reg;
        bank_next     = bank_reg;
        acc_next      = acc_reg;
        wr_valid_next = 1'b0;
        wr_idx_next   = wr_idx_reg;
        x_next        = x_reg;
        prod_lo_next  = prod_lo_reg;
        prod_hi_next  = prod_hi_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    len_next   = s_tdata[LEN_W-1:0];
                    rad_next   = s_tdata[LEN_W+RAD_W-1:LEN_W];
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                acc_next  = '0;
                top_next  = '0;
                idx_next  = '0;
                pass_next = '0;
                init_next = 1'b1;
                bank_next = 1'b0;
                if (bad)
                    state_next = ST_DONE;
                else if (half == '0)
                    state_next = ST_SQ_RD;
                else
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                wr_valid_next = 1'b1;
                wr_idx_next   = idx_reg;
                if (wr_valid_reg)
                    acc_next = wsum;
                if (idx_reg == last)
                    state_next = ST_CONV_END;
                else
                    idx_next = idx_reg + AW'(1);
            end
            ST_CONV_END:
            begin
                // the last write of the pass lands this cycle
                acc_next  = '0;
                top_next  = last;
                bank_next = !bank_reg;
                init_next = 1'b0;
                idx_next  = '0;
                pass_next = pass_inc;
                state_next = (pass_inc == half) ? ST_SQ_RD : ST_CONV;
            end
            ST_SQ_RD:
            begin
                state_next = ST_SQ_M1;
            end
            ST_SQ_M1:
            begin
                x_next       = val_a;
                prod_lo_next = mul_p;
                state_next   = ST_SQ_M2;
            end
            ST_SQ_M2:
            begin
                prod_hi_next = mul_p[MUL_W-1:0];
                state_next   = ST_SQ_ACC;
            end
            ST_SQ_ACC:
            begin
                // low 64 bits of x*x: lo*lo + 2*lo*hi shifted up by 32
                acc_next = acc_reg + prod_lo_reg + {prod_hi_reg[MUL_W-2:0], {(MUL_W+1){1'b0}}};
                if (idx_reg == top_reg)
                    state_next = len_reg[0] ? ST_ODD_M1 : ST_DONE;
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = ST_SQ_RD;
                end
            end
            ST_ODD_M1:
            begin
                prod_lo_next = mul_p;
                state_next   = ST_ODD_M2;
            end
            ST_ODD_M2:
            begin
                prod_hi_next = mul_p[MUL_W-1:0];
                state_next   = ST_ODD_ACC;
            end
            ST_ODD_ACC:
            begin
                acc_next   = prod_lo_reg + {prod_hi_reg, {MUL_W{1'b0}}};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            top_reg      <= '0;
            idx_reg      <= '0;
            pass_reg     <= '0;
            init_reg     <= 1'b0;
            bank_reg     <= 1'b0;
            acc_reg      <= '0;
            wr_valid_reg <= 1'b0;
            sel_a_reg    <= SEL_ZERO;
            sel_b_reg    <= SEL_ZERO;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            idx_reg      <= idx_next;
            pass_reg     <= pass_next;
            init_reg     <= init_next;
            bank_reg     <= bank_next;
            acc_reg      <= acc_next;
            wr_valid_reg <= wr_valid_next;
            sel_a_reg    <= sel_a_next;
            sel_b_reg    <= sel_b_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        rad_reg     <= rad_next;
        wr_idx_reg  <= wr_idx_next;
        x_reg       <= x_next;
        prod_lo_reg <= prod_lo_next;
        prod_hi_reg <= prod_hi_next;
        m_tdata_reg <= m_tdata_next;
    end

    // histogram tables, two banks: read the source bank, write the other one
    always_ff @(posedge clk)
    begin
        if (wr_valid_reg)
            hist_mem[{!bank_reg, wr_idx_reg}] <= wsum;
        rd_a_reg <= hist_mem[{bank_reg, idx_reg}];
        rd_b_reg <= hist_mem[{bank_reg, idx_b}];
    end

`ifndef NO_ASSERTIONS
    a_wr_only_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (state_reg == ST_CONV || state_reg == ST_CONV_END))
        else $error("table write outside a convolution pass");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (idx_reg <= last))
        else $error("convolution sweep ran past the last sum");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_START))
        else $error("accepted transaction did not start the sequencer");
`endif

endmodule

`default_nettype wire
